// ===== rtl/core/vmdc_pkg.sv =====
// Shared types, constants and the glyph table for the voltage monitor display controller.
`timescale 1ns / 1ps
`default_nettype none
package vmdc_pkg;

  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned VOLTS_W    = 8;
  localparam int unsigned SUM_W      = 18;
  localparam int unsigned COUNT_W    = 10;
  localparam int unsigned REM_W      = 10;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned CODE_W     = 6;
  localparam int unsigned SEG_W      = 8;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned GLYPH_COUNT = 52;

  // Divider run lengths: full sum for the average, one byte for the digits.
  localparam logic [STEP_W-1:0] AVG_STEPS = 5'd18;
  localparam logic [STEP_W-1:0] DIG_STEPS = 5'd8;

  localparam logic [SEG_W-1:0]  SEG_DP_BIT = 8'h80;
  localparam logic [CODE_W-1:0] GLYPH_E  = 6'd19;
  localparam logic [CODE_W-1:0] GLYPH_R  = 6'd20;

  localparam logic [COUNT_W-1:0] AVG_COUNT_RST     = 10'd300;
  localparam logic [VOLTS_W-1:0] UP_VOLTS_RST      = 8'd160;
  localparam logic [VOLTS_W-1:0] DOWN_VOLTS_RST    = 8'd140;
  localparam logic [VOLTS_W-1:0] FLOOR_VOLTS_RST   = 8'd105;
  localparam logic [VOLTS_W-1:0] LAMP_VOLTS_RST    = 8'd132;
  localparam logic [VOLTS_W-1:0] ERROR_VOLTS_RST   = 8'd132;
  localparam logic [VOLTS_W-1:0] DISPLAY_FLOOR_RST = 8'd100;

  typedef enum logic [2:0] {
    REG_AVG_COUNT     = 3'd0,
    REG_UP_VOLTS      = 3'd1,
    REG_DOWN_VOLTS    = 3'd2,
    REG_FLOOR_VOLTS   = 3'd3,
    REG_LAMP_VOLTS    = 3'd4,
    REG_ERROR_VOLTS   = 3'd5,
    REG_DISPLAY_FLOOR = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    MOTOR_STOP = 2'd0,
    MOTOR_UP   = 2'd1,
    MOTOR_DOWN = 2'd2
  } motor_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AVG,
    ST_DIG,
    ST_DONE
  } vmdc_state_e;

  typedef enum logic [1:0] {
    DIGIT_HUNDREDS = 2'd0,
    DIGIT_TENS     = 2'd1,
    DIGIT_ONES     = 2'd2
  } digit_e;

  // Divider launch request.
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  function automatic logic [SEG_W-1:0] glyph_lookup(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] seg;
    case (code)
      6'd0:  seg = 8'h3F;  6'd1:  seg = 8'h06;  6'd2:  seg = 8'h5B;  6'd3:  seg = 8'h4F;
      6'd4:  seg = 8'h66;  6'd5:  seg = 8'h6D;  6'd6:  seg = 8'h7D;  6'd7:  seg = 8'h07;
      6'd8:  seg = 8'h7F;  6'd9:  seg = 8'h6F;  6'd10: seg = 8'h00;  6'd11: seg = 8'h39;
      6'd12: seg = 8'h73;  6'd13: seg = 8'h78;  6'd14: seg = 8'h5C;  6'd15: seg = 8'h3F;
      6'd16: seg = 8'h37;  6'd17: seg = 8'h71;  6'd18: seg = 8'h6E;  6'd19: seg = 8'h79;
      6'd20: seg = 8'h50;  6'd21: seg = 8'h38;  6'd22: seg = 8'h54;  6'd23: seg = 8'h40;
      6'd24: seg = 8'h76;  6'd25: seg = 8'h1C;  6'd26: seg = 8'h3E;  6'd27: seg = 8'h77;
      6'd28: seg = 8'h6D;  6'd29: seg = 8'hFF;  6'd30: seg = 8'hBF;  6'd31: seg = 8'h86;
      6'd32: seg = 8'hDB;  6'd33: seg = 8'hCF;  6'd34: seg = 8'hE6;  6'd35: seg = 8'hED;
      6'd36: seg = 8'hFD;  6'd37: seg = 8'h87;  6'd38: seg = 8'hFF;  6'd39: seg = 8'hEF;
      6'd40: seg = 8'h3F;  6'd41: seg = 8'h55;  6'd42: seg = 8'h67;  6'd43: seg = 8'h53;
      6'd44: seg = 8'h20;  6'd45: seg = 8'h80;  6'd46: seg = 8'h7C;  6'd47: seg = 8'h5E;
      6'd48: seg = 8'h6A;  6'd49: seg = 8'h10;  6'd50: seg = 8'h63;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/vmdc_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module vmdc_divider
  import vmdc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire div_req_t         req_i,
  input  wire logic [SUM_W-1:0] dividend_i,  // left aligned to the step count
  input  wire logic [REM_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [SUM_W-1:0]      quotient_o,
  output logic [REM_W-1:0]      remainder_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [REM_W-1:0]  div_q, div_d;

  logic [REM_W:0]    shifted_w;
  logic [REM_W+1:0]  diff_w;

  assign shifted_w = {rem_q, quo_q[SUM_W-1]};
  assign diff_w    = {1'b0, shifted_w} - {2'b00, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      // keep the trial difference when it does not borrow
      if (!diff_w[REM_W+1]) begin
        rem_d = diff_w[REM_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = shifted_w[REM_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule
`default_nettype wire

// ===== rtl/core/voltage_monitor_display_controller_core.sv =====
// Voltage monitor: scale, window average, seven-segment mux, lift and lamp control.
// Each word runs the shared divider for its decimal digits; the word that closes a window first
// runs it over the full sum width for the window average, then over one byte for the digits.
// A new word is taken only while the sequencer is idle, so the divider and the output register set the word rate.
// The result sits in an output register; a new word is accepted while it waits.
// Reset (rst_ni low, asynchronous): clear sum, count, average, mux position and digits,
//   lamp on, drive stopped, configuration back to its defaults.
`timescale 1ns / 1ps
`default_nettype none
module voltage_monitor_display_controller_core
  import vmdc_pkg::*;
#(
  parameter int unsigned GlyphCount = GLYPH_COUNT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [9:0] adc_sample
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [7:0] segment_pattern, [9:8] digit_index,
                                                     // [11:10] motor_command, [12] right_lamp_on,
                                                     // [13] low_voltage_error,
                                                     // [21:14] average_volts
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] avg_count_q;
  logic [VOLTS_W-1:0] up_volts_q, down_volts_q, floor_volts_q;
  logic [VOLTS_W-1:0] lamp_volts_q, error_volts_q, display_floor_q;

  logic     cfg_wr_w;
  reg_idx_e cfg_idx_w;

  assign pready    = 1'b1;
  assign cfg_wr_w  = psel & penable & pwrite & pready;
  assign cfg_idx_w = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_count_q     <= AVG_COUNT_RST;
      up_volts_q      <= UP_VOLTS_RST;
      down_volts_q    <= DOWN_VOLTS_RST;
      floor_volts_q   <= FLOOR_VOLTS_RST;
      lamp_volts_q    <= LAMP_VOLTS_RST;
      error_volts_q   <= ERROR_VOLTS_RST;
      display_floor_q <= DISPLAY_FLOOR_RST;
    end else if (cfg_wr_w) begin
      case (cfg_idx_w)
        REG_AVG_COUNT:     avg_count_q     <= pwdata[COUNT_W-1:0];
        REG_UP_VOLTS:      up_volts_q      <= pwdata[VOLTS_W-1:0];
        REG_DOWN_VOLTS:    down_volts_q    <= pwdata[VOLTS_W-1:0];
        REG_FLOOR_VOLTS:   floor_volts_q   <= pwdata[VOLTS_W-1:0];
        REG_LAMP_VOLTS:    lamp_volts_q    <= pwdata[VOLTS_W-1:0];
        REG_ERROR_VOLTS:   error_volts_q   <= pwdata[VOLTS_W-1:0];
        REG_DISPLAY_FLOOR: display_floor_q <= pwdata[VOLTS_W-1:0];
        default: ;  // no register at this address
      endcase
    end
  end

  always_comb begin
    case (cfg_idx_w)
      REG_AVG_COUNT:     prdata = 32'(avg_count_q);
      REG_UP_VOLTS:      prdata = 32'(up_volts_q);
      REG_DOWN_VOLTS:    prdata = 32'(down_volts_q);
      REG_FLOOR_VOLTS:   prdata = 32'(floor_volts_q);
      REG_LAMP_VOLTS:    prdata = 32'(lamp_volts_q);
      REG_ERROR_VOLTS:   prdata = 32'(error_volts_q);
      REG_DISPLAY_FLOOR: prdata = 32'(display_floor_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Block state
  // ---------------------------------------------------------------------------
  vmdc_state_e        state_q, state_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [VOLTS_W-1:0] avg_q, avg_d;
  logic [1:0]         mux_q, mux_d;
  logic [CODE_W-1:0]  codes_q [3];
  logic [CODE_W-1:0]  codes_d [3];
  logic               lamp_q, lamp_d;
  motor_e             last_cmd_q, last_cmd_d;

  // per-word payload held while the divider runs
  logic [VOLTS_W-1:0] volts_q, volts_d;
  logic [SEG_W-1:0]   pattern_q, pattern_d;
  logic [1:0]         lit_q, lit_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  // ---------------------------------------------------------------------------
  // Sample scaling: 100 + floor(sample * 100 / 1024)
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0]  sample_w;
  logic [SAMPLE_W+6:0]  prod_w;
  logic [VOLTS_W-1:0]   volts_w;

  assign sample_w = s_axis_tdata[SAMPLE_W-1:0];
  assign prod_w   = 17'(sample_w) * 17'd100;
  assign volts_w  = 8'd100 + {1'b0, prod_w[16:10]};

  // ---------------------------------------------------------------------------
  // Window accumulation
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] window_w;
  logic [SUM_W-1:0]   sum_inc_w;
  logic [COUNT_W-1:0] cnt_inc_w;
  logic               close_w;
  logic               accept_w;

  assign window_w  = (avg_count_q == '0) ? 10'd1 : avg_count_q;  // zero length acts as one
  assign sum_inc_w = sum_q + 18'(volts_w);
  assign cnt_inc_w = cnt_q + 10'd1;
  assign close_w   = (cnt_inc_w >= window_w);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept_w      = s_axis_tvalid & s_axis_tready;

  // ---------------------------------------------------------------------------
  // Display mux: show the digit from the codes left by the previous word
  // ---------------------------------------------------------------------------
  logic [CODE_W-1:0] mux_code_w;
  logic [SEG_W-1:0]  mux_seg_w;

  always_comb begin
    case (mux_q)
      2'd0:    mux_code_w = codes_q[0];
      2'd1:    mux_code_w = codes_q[1];
      default: mux_code_w = codes_q[2];
    endcase
    // codes past the glyph count show blank
    if ({1'b0, mux_code_w} >= 7'(GlyphCount)) begin
      mux_seg_w = '0;
    end else begin
      mux_seg_w = glyph_lookup(mux_code_w);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared divider
  // ---------------------------------------------------------------------------
  div_req_t           div_req_w;
  logic [SUM_W-1:0]   div_dividend_w;
  logic [REM_W-1:0]   div_divisor_w;
  logic               div_done_w;
  logic [SUM_W-1:0]   div_quo_w;
  logic [REM_W-1:0]   div_rem_w;

  vmdc_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req_w),
    .dividend_i  (div_dividend_w),
    .divisor_i   (div_divisor_w),
    .done_o      (div_done_w),
    .quotient_o  (div_quo_w),
    .remainder_o (div_rem_w)
  );

  // ---------------------------------------------------------------------------
  // Digit split from s / 10: the quotient stays below twice ten
  // ---------------------------------------------------------------------------
  logic [VOLTS_W-1:0] tens_q10_w;
  logic [CODE_W-1:0]  hund_code_w, tens_code_w, ones_code_w;

  assign tens_q10_w  = div_quo_w[VOLTS_W-1:0];
  assign hund_code_w = (tens_q10_w >= 8'd10) ? 6'd1 : 6'd0;
  assign tens_code_w = (tens_q10_w >= 8'd10) ? 6'(tens_q10_w - 8'd10) : 6'(tens_q10_w);
  assign ones_code_w = 6'(div_rem_w);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic   err_w;
  motor_e cmd_w;
  logic   lamp_w;

  // lift decision and lamp for the held sample
  always_comb begin
    lamp_w = lamp_q;
    if (volts_q > up_volts_q) begin
      cmd_w = MOTOR_UP;
    end else if (volts_q < down_volts_q && volts_q > floor_volts_q) begin
      cmd_w = MOTOR_DOWN;
      if (volts_q < lamp_volts_q) begin
        lamp_w = 1'b0;
      end
    end else begin
      cmd_w  = MOTOR_STOP;
      lamp_w = 1'b1;
    end
  end

  // error looks at the drive left by the previous word
  assign err_w = (avg_q < error_volts_q) && (last_cmd_q == MOTOR_DOWN);

  always_comb begin
    state_d        = state_q;
    sum_d          = sum_q;
    cnt_d          = cnt_q;
    avg_d          = avg_q;
    mux_d          = mux_q;
    codes_d        = codes_q;
    lamp_d         = lamp_q;
    last_cmd_d     = last_cmd_q;
    volts_d        = volts_q;
    pattern_d      = pattern_q;
    lit_d          = lit_q;
    out_valid_d    = out_valid_q;
    out_data_d     = out_data_q;
    div_req_w      = '{start: 1'b0, steps: DIG_STEPS};
    div_dividend_w = {volts_q, 10'b0};
    div_divisor_w  = 10'd10;

    // drop the result once taken
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept_w) begin
          volts_d = volts_w;
          // latch the lit digit and advance the mux
          case (mux_q)
            2'd0: begin
              pattern_d = mux_seg_w | SEG_DP_BIT;
              lit_d     = DIGIT_HUNDREDS;
              mux_d     = 2'd1;
            end
            2'd1: begin
              pattern_d = mux_seg_w;
              lit_d     = DIGIT_TENS;
              mux_d     = 2'd2;
            end
            default: begin
              pattern_d = mux_seg_w;
              lit_d     = DIGIT_ONES;
              mux_d     = 2'd0;
            end
          endcase
          if (close_w) begin
            // window complete: divide the sum, clear the accumulator
            sum_d          = '0;
            cnt_d          = '0;
            div_req_w      = '{start: 1'b1, steps: AVG_STEPS};
            div_dividend_w = sum_inc_w;
            div_divisor_w  = window_w;
            state_d        = ST_AVG;
          end else begin
            sum_d          = sum_inc_w;
            cnt_d          = cnt_inc_w;
            div_req_w      = '{start: 1'b1, steps: DIG_STEPS};
            div_dividend_w = {volts_w, 10'b0};
            state_d        = ST_DIG;
          end
        end
      end
      ST_AVG: begin
        if (div_done_w) begin
          avg_d     = div_quo_w[VOLTS_W-1:0];
          div_req_w = '{start: 1'b1, steps: DIG_STEPS};
          state_d   = ST_DIG;
        end
      end
      ST_DIG: begin
        if (div_done_w) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          if (avg_q <= display_floor_q) begin
            codes_d[0] = GLYPH_E;
            codes_d[1] = GLYPH_R;
            codes_d[2] = GLYPH_R;
          end else begin
            codes_d[0] = hund_code_w;
            codes_d[1] = tens_code_w;
            codes_d[2] = ones_code_w;
          end
          lamp_d      = lamp_w;
          last_cmd_d  = cmd_w;
          out_valid_d = 1'b1;
          out_data_d  = {2'b00, avg_q, err_w, lamp_w, cmd_w, lit_q, pattern_q};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      avg_q       <= '0;
      mux_q       <= '0;
      codes_q[0]  <= '0;
      codes_q[1]  <= '0;
      codes_q[2]  <= '0;
      lamp_q      <= 1'b1;
      last_cmd_q  <= MOTOR_STOP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      avg_q       <= avg_d;
      mux_q       <= mux_d;
      codes_q     <= codes_d;
      lamp_q      <= lamp_d;
      last_cmd_q  <= last_cmd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    volts_q    <= volts_d;
    pattern_q  <= pattern_d;
    lit_q      <= lit_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

// ===== tb/sv/voltage_monitor_display_controller_core_test.sv =====
// Self-checking testbench for the voltage monitor display controller core.
`timescale 1ns / 1ps
module voltage_monitor_display_controller_core_test;
  import vmdc_pkg::*;

  // Give up well past the slowest legal run: about 1225 words, each with its divider runs,
  // plus setting writes and drains.
  localparam int unsigned CYCLE_LIMIT = 500_000;
  // Hold this long after the last result so a stray extra word still gets caught.
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned PHASES_PER_MODE = 4;
  localparam int unsigned WORDS_PER_PHASE = 100;

  // Segment patterns by glyph index; the dot is bit 7.
  localparam logic [0:51][7:0] SEG_ROM = {
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F, 8'h00, 8'h39, 8'h73,
    8'h78, 8'h5C, 8'h3F, 8'h37, 8'h71, 8'h6E, 8'h79, 8'h50, 8'h38, 8'h54, 8'h40, 8'h76, 8'h1C,
    8'h3E, 8'h77, 8'h6D, 8'hFF, 8'hBF, 8'h86, 8'hDB, 8'hCF, 8'hE6, 8'hED, 8'hFD, 8'h87, 8'hFF,
    8'hEF, 8'h3F, 8'h55, 8'h67, 8'h53, 8'h20, 8'h80, 8'h7C, 8'h5E, 8'h6A, 8'h10, 8'h63, 8'h00
  };

  // One display/lift readout, as carried in m_axis_tdata.
  typedef struct packed {
    logic [7:0] seg;
    digit_e     digit;
    motor_e     motor;
    logic       lamp;
    logic       err;
    logic [7:0] avg;
  } readout_t;

  typedef enum logic {
    ROW_WORD,
    ROW_SETTING
  } row_kind_e;

  // One line of the directed plan: a sample word or a setting write.
  typedef struct packed {
    row_kind_e   kind;
    reg_idx_e    reg_sel;
    logic [31:0] value;
    logic        typed;
    readout_t    exp;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  voltage_monitor_display_controller_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [9:0] adc_sample
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [7:0] segment, [9:8] digit, [11:10] motor, [12] lamp,
                                     // [13] low-voltage error, [21:14] average volts
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the settings.
  logic [9:0] cfg_avg_count;
  logic [7:0] cfg_up, cfg_down, cfg_floor, cfg_lamp, cfg_error, cfg_disp_floor;

  // Shadow copy of the block state.
  logic [17:0] volt_sum;
  logic [9:0]  volt_count;
  logic [7:0]  window_avg;
  logic [1:0]  mux_pos;
  logic [5:0]  digit_code [3];
  logic        lamp_state;
  motor_e      last_drive;

  readout_t    pending_readouts[$];
  plan_row_t   plan[$];

  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 76;
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned readouts_seen = 0;
  int unsigned windows_closed = 0;
  int unsigned setting_writes = 0;
  int unsigned drive_seen [3] = '{0, 0, 0};
  int unsigned cycle_cnt = 0;

  function automatic logic [7:0] seg_of(input logic [5:0] code);
    return (code >= GLYPH_COUNT) ? 8'h00 : SEG_ROM[code];
  endfunction

  // Advance the shadow state by one sample and produce the readout it causes.
  task automatic predict_readout(input logic [9:0] smp, output readout_t r);
    int unsigned volts;
    int unsigned window;
    volts = 100 + ((32'(smp) * 100) >> 10);
    // The lit digit comes from the codes left by the previous sample.
    case (mux_pos)
      2'd0: begin
        r.seg = seg_of(digit_code[0]) | SEG_DP_BIT;
        r.digit = DIGIT_HUNDREDS;
        mux_pos = 2'd1;
      end
      2'd1: begin
        r.seg = seg_of(digit_code[1]);
        r.digit = DIGIT_TENS;
        mux_pos = 2'd2;
      end
      default: begin
        r.seg = seg_of(digit_code[2]);
        r.digit = DIGIT_ONES;
        mux_pos = 2'd0;
      end
    endcase
    // A window length of zero behaves as one.
    window = (cfg_avg_count == 10'd0) ? 1 : 32'(cfg_avg_count);
    volt_sum = 18'(32'(volt_sum) + volts);
    volt_count = volt_count + 10'd1;
    if (32'(volt_count) >= window) begin
      window_avg = 8'(32'(volt_sum) / window);
      volt_sum = '0;
      volt_count = '0;
      windows_closed++;
    end
    r.err = (window_avg < cfg_error) && (last_drive == MOTOR_DOWN);
    if (window_avg <= cfg_disp_floor) begin
      digit_code[0] = GLYPH_E;
      digit_code[1] = GLYPH_R;
      digit_code[2] = GLYPH_R;
    end else begin
      digit_code[0] = 6'((volts / 100) % 10);
      digit_code[1] = 6'((volts / 10) % 10);
      digit_code[2] = 6'(volts % 10);
    end
    // Lamp holds while going up or lowering at/above the lamp threshold.
    if (volts > 32'(cfg_up)) begin
      r.motor = MOTOR_UP;
    end else if (volts < 32'(cfg_down) && volts > 32'(cfg_floor)) begin
      r.motor = MOTOR_DOWN;
      if (volts < 32'(cfg_lamp)) lamp_state = 1'b0;
    end else begin
      r.motor = MOTOR_STOP;
      lamp_state = 1'b1;
    end
    last_drive = r.motor;
    drive_seen[r.motor]++;
    r.lamp = lamp_state;
    r.avg = window_avg;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
               $time, name, want, want, got, got);
      errors++;
    end
  endtask

  // Output side: accept at the rising edge, compare with the oldest pending readout.
  always @(posedge clk_i) begin
    readout_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: run stopped at the cycle limit, %0d readouts still pending",
               $time, pending_readouts.size());
      $display("FAILURE");
      $finish;
    end else if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      readouts_seen++;
      if (pending_readouts.size() == 0) begin
        $display("%0t: unexpected word 0x%0h, expected none", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_readouts.pop_front();
        check_field("segment_pattern", want.seg, m_axis_tdata[7:0]);
        check_field("digit_index", want.digit, m_axis_tdata[9:8]);
        check_field("motor_command", want.motor, m_axis_tdata[11:10]);
        check_field("right_lamp_on", want.lamp, m_axis_tdata[12]);
        check_field("low_voltage_error", want.err, m_axis_tdata[13]);
        check_field("average_volts", want.avg, m_axis_tdata[21:14]);
      end
    end
  end

  // Receiver stalls, redrawn every cycle.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Send one sample word. Enter and leave at a falling edge with s_axis_tvalid untouched.
  task automatic push_word(input logic [9:0] smp, input logic typed, input readout_t exp);
    readout_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, smp};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_readout(smp, pred);
    pending_readouts.push_back(typed ? exp : pred);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every pending readout has come back.
  task automatic drain_readouts();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_readouts.size() != 0) @(negedge clk_i);
  endtask

  // Write one register over APB, read it back, and mirror it in the shadow settings.
  task automatic write_setting(input reg_idx_e sel, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'({sel, 2'b00});
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (sel)
      REG_AVG_COUNT:     cfg_avg_count = value[9:0];
      REG_UP_VOLTS:      cfg_up = value[7:0];
      REG_DOWN_VOLTS:    cfg_down = value[7:0];
      REG_FLOOR_VOLTS:   cfg_floor = value[7:0];
      REG_LAMP_VOLTS:    cfg_lamp = value[7:0];
      REG_ERROR_VOLTS:   cfg_error = value[7:0];
      REG_DISPLAY_FLOOR: cfg_disp_floor = value[7:0];
      default: ;
    endcase
    setting_writes++;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata != value) begin
      $display("%0t: readback of %s, expected 0x%0h, got 0x%0h",
               $time, sel.name(), value, prdata);
      errors++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Draw fresh values for every setting for a random phase, extremes included now and then.
  task automatic pick_setting();
    int unsigned sel;
    logic [31:0] value;
    sel = $urandom_range(9);
    case (sel)
      0:       value = 1;
      1:       value = 0;
      2:       value = 1023;
      3, 4:    value = $urandom_range(2, 8);
      5, 6, 7: value = $urandom_range(9, 40);
      default: value = $urandom_range(41, 300);
    endcase
    write_setting(REG_AVG_COUNT, value);
    for (int k = 1; k <= 5; k++) begin
      value = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(100, 200);
      write_setting(reg_idx_e'(k), value);
    end
    value = ($urandom_range(7) == 0) ? 255 : $urandom_range(0, 200);
    write_setting(REG_DISPLAY_FLOOR, value);
  endtask

  // Land on a threshold edge or spread over the whole range, with the two extremes now and then.
  function automatic logic [9:0] pick_sample();
    int volts;
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return ($urandom_range(1) != 0) ? 10'd1023 : 10'd0;
    if (sel >= 5) return 10'($urandom_range(1023));
    case ($urandom_range(4))
      0:       volts = int'(cfg_up);
      1:       volts = int'(cfg_down);
      2:       volts = int'(cfg_floor);
      3:       volts = int'(cfg_lamp);
      default: volts = int'(cfg_error);
    endcase
    volts = volts + int'($urandom_range(2)) - 1;
    if (volts < 100 || volts > 199) return 10'($urandom_range(1023));
    // Smallest sample that scales to exactly this voltage.
    return 10'(((volts - 100) * 1024 + 99) / 100);
  endfunction

  function automatic plan_row_t word_row(input logic [9:0] smp);
    return '{ROW_WORD, REG_AVG_COUNT, {22'd0, smp}, 1'b0, readout_t'('0)};
  endfunction

  function automatic plan_row_t typed_row(input logic [9:0] smp, input readout_t exp);
    return '{ROW_WORD, REG_AVG_COUNT, {22'd0, smp}, 1'b1, exp};
  endfunction

  function automatic plan_row_t setting_row(input reg_idx_e sel, input logic [31:0] value);
    return '{ROW_SETTING, sel, value, 1'b0, readout_t'('0)};
  endfunction

  initial begin
    int unsigned pause_at;

    // Settings and state as they come out of reset.
    cfg_avg_count = 10'd300;
    cfg_up = 8'd160;
    cfg_down = 8'd140;
    cfg_floor = 8'd105;
    cfg_lamp = 8'd132;
    cfg_error = 8'd132;
    cfg_disp_floor = 8'd100;
    volt_sum = '0;
    volt_count = '0;
    window_avg = '0;
    mux_pos = '0;
    digit_code[0] = '0;
    digit_code[1] = '0;
    digit_code[2] = '0;
    lamp_state = 1'b1;
    last_drive = MOTOR_STOP;

    // Directed plan. Right after reset the display shows zero with the dot, then "Err".
    plan.push_back(typed_row(10'd0,
                             '{8'hBF, DIGIT_HUNDREDS, MOTOR_STOP, 1'b1, 1'b0, 8'd0}));
    plan.push_back(typed_row(10'd1023,
                             '{8'h50, DIGIT_TENS, MOTOR_UP, 1'b1, 1'b0, 8'd0}));
    plan.push_back(typed_row(10'd512,
                             '{8'h50, DIGIT_ONES, MOTOR_STOP, 1'b1, 1'b0, 8'd0}));
    plan.push_back(typed_row(10'd300,
                             '{8'hF9, DIGIT_HUNDREDS, MOTOR_DOWN, 1'b0, 1'b0, 8'd0}));
    // Lowering with no average yet raises the low-voltage error.
    plan.push_back(typed_row(10'd300,
                             '{8'h50, DIGIT_TENS, MOTOR_DOWN, 1'b0, 1'b1, 8'd0}));
    // Threshold edges: floor, lamp, down band top, up.
    plan.push_back(word_row(10'd61));
    plan.push_back(word_row(10'd62));
    plan.push_back(word_row(10'd328));
    plan.push_back(word_row(10'd410));
    plan.push_back(word_row(10'd615));
    plan.push_back(word_row(10'd625));
    plan.push_back(word_row(10'h155));
    plan.push_back(word_row(10'h2AA));
    // Zero window length acts as one: every word closes a window.
    plan.push_back(setting_row(REG_AVG_COUNT, 32'd0));
    plan.push_back(word_row(10'd1023));
    plan.push_back(word_row(10'd0));
    plan.push_back(word_row(10'd1));
    // Longest window, then shorten it mid-window so it closes on the next word.
    plan.push_back(setting_row(REG_AVG_COUNT, 32'd1023));
    plan.push_back(setting_row(REG_DISPLAY_FLOOR, 32'd200));
    plan.push_back(word_row(10'd1023));
    plan.push_back(word_row(10'd512));
    plan.push_back(word_row(10'd0));
    plan.push_back(word_row(10'd700));
    plan.push_back(setting_row(REG_AVG_COUNT, 32'd2));
    plan.push_back(word_row(10'd1023));
    // Thresholds outside their usual range are taken as written.
    plan.push_back(setting_row(REG_UP_VOLTS, 32'd255));
    plan.push_back(setting_row(REG_DOWN_VOLTS, 32'd255));
    plan.push_back(setting_row(REG_FLOOR_VOLTS, 32'd0));
    plan.push_back(setting_row(REG_LAMP_VOLTS, 32'd255));
    plan.push_back(setting_row(REG_ERROR_VOLTS, 32'd255));
    plan.push_back(setting_row(REG_DISPLAY_FLOOR, 32'd255));
    plan.push_back(word_row(10'd1023));
    plan.push_back(word_row(10'd0));
    plan.push_back(word_row(10'd512));
    plan.push_back(setting_row(REG_UP_VOLTS, 32'd0));
    plan.push_back(setting_row(REG_DISPLAY_FLOOR, 32'd0));
    plan.push_back(word_row(10'd0));
    plan.push_back(word_row(10'd1023));

    // Hold reset, then release it once.
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed plan; settings change only with nothing in flight.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SETTING) begin
        drain_readouts();
        write_setting(plan[i].reg_sel, plan[i].value);
      end else begin
        push_word(plan[i].value[9:0], plan[i].typed, plan[i].exp);
      end
    end

    // Random part: eager sender and busy receiver, then the reverse, then no idling.
    for (int mode = 0; mode < 3; mode++) begin
      drain_readouts();
      send_idle_pct = (mode == 0) ? 18 : (mode == 1) ? 76 : 0;
      recv_idle_pct = (mode == 0) ? 76 : (mode == 1) ? 18 : 0;
      for (int phase = 0; phase < PHASES_PER_MODE; phase++) begin
        drain_readouts();
        pick_setting();
        pause_at = $urandom_range(10, WORDS_PER_PHASE - 10);
        for (int n = 0; n < WORDS_PER_PHASE; n++) begin
          // Let the block run dry once per phase before going on.
          if (n == pause_at) drain_readouts();
          push_word(pick_sample(), 1'b0, readout_t'('0));
        end
      end
    end

    drain_readouts();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Sent %0d sample words under %0d setting writes; %0d readouts, %0d windows closed.",
             words_sent, setting_writes, readouts_seen, windows_closed);
    $display("Lift commands seen: %0d stop, %0d up, %0d down; %0d mismatches.",
             drive_seen[MOTOR_STOP], drive_seen[MOTOR_UP], drive_seen[MOTOR_DOWN], errors);
    if (errors == 0 && pending_readouts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
